// ----- sv/pj_pkg.sv -----
// Shared types, constants and fixed-point helpers for the projection Jacobian block.
package pj_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int WORD_WIDTH = 32;
  localparam int PROD_W     = 2 * WORD_WIDTH;
  localparam int FOCAL_W    = 31;

  // Divider: quotient bits kept below the saturation point, bits per stage.
  localparam int DIV_BITS  = WORD_WIDTH - 1;
  localparam int DIV_STEP  = 2;
  localparam int DIV_ITER  = (DIV_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_LAT   = DIV_ITER + 2;
  localparam int DIV_LANES = 4;
  localparam int HI_SH     = DIV_BITS - FRAC_BITS;

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic signed [PROD_W-1:0]     wide_t;
  typedef logic [FOCAL_W-1:0]           focal_t;
  typedef logic [0:0]                   cfg_idx_t;

  localparam cfg_idx_t CFG_FOCAL_X = 1'b0;
  localparam cfg_idx_t CFG_FOCAL_Y = 1'b1;

  localparam focal_t FOCAL_RESET = 31'd32768000;

  localparam word_t WORD_MAX  = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam word_t WORD_MIN  = {1'b1, {(WORD_WIDTH-1){1'b0}}};
  localparam word_t WORD_ONE  = WORD_WIDTH'(1) << FRAC_BITS;
  localparam word_t WORD_ZERO = '0;

  typedef struct packed {
    word_t quat_w;
    word_t quat_x;
    word_t quat_y;
    word_t quat_z;
    word_t trans_x;
    word_t trans_y;
    word_t trans_z;
    word_t point_x;
    word_t point_y;
    word_t point_z;
  } in_t;

  typedef struct packed {
    word_t pose_d0;
    word_t pose_d1;
    word_t pose_d2;
    word_t pose_d3;
    word_t pose_d4;
    word_t pose_d5;
    word_t point_d0;
    word_t point_d1;
    word_t point_d2;
    logic  last_row;
    logic  bad_depth;
  } out_t;

  typedef struct packed {
    logic [DIV_BITS-1:0] rem;
    logic [DIV_BITS-1:0] nq;
    logic                neg;
    logic                ovf;
  } div_lane_t;

  function automatic word_t sat_w(wide_t v);
    word_t r;
    if (v > wide_t'(WORD_MAX)) begin
      r = WORD_MAX;
    end else if (v < wide_t'(WORD_MIN)) begin
      r = WORD_MIN;
    end else begin
      r = v[WORD_WIDTH-1:0];
    end
    return r;
  endfunction

  // Round half up, then saturate.
  function automatic word_t qmul(word_t a, word_t b);
    wide_t p;
    p = wide_t'(a) * wide_t'(b);
    p = p + (wide_t'(1) <<< (FRAC_BITS - 1));
    return sat_w(p >>> FRAC_BITS);
  endfunction

  function automatic word_t qadd(word_t a, word_t b);
    return sat_w(wide_t'(a) + wide_t'(b));
  endfunction

  function automatic word_t qsub(word_t a, word_t b);
    return sat_w(wide_t'(a) - wide_t'(b));
  endfunction

  function automatic word_t dbl(word_t a);
    return qadd(a, a);
  endfunction

  // One restoring step: shift in the next numerator bit, shift out a quotient bit.
  function automatic div_lane_t div_step(div_lane_t l, logic [DIV_BITS-1:0] d);
    logic [DIV_BITS:0] r2;
    logic              ge;
    div_lane_t         o;
    r2 = {l.rem, l.nq[DIV_BITS-1]};
    ge = r2 >= {1'b0, d};
    o = l;
    o.nq = {l.nq[DIV_BITS-2:0], ge};
    o.rem = ge ? DIV_BITS'(r2 - {1'b0, d}) : r2[DIV_BITS-1:0];
    return o;
  endfunction

endpackage

// ----- sv/pj_div.sv -----
// Four-lane pipelined fixed-point divider sharing one positive denominator.
module pj_div (
  input  logic                    clk,
  input  logic [pj_pkg::DIV_LAT-1:0] ld,
  input  pj_pkg::word_t           num [pj_pkg::DIV_LANES],
  input  pj_pkg::word_t           den,
  output pj_pkg::word_t           quo [pj_pkg::DIV_LANES],
  output logic                    bad
);
  import pj_pkg::*;

  div_lane_t           st  [DIV_ITER+1][DIV_LANES];
  logic [DIV_BITS-1:0] dv  [DIV_ITER+1];
  logic                bd  [DIV_ITER+1];
  div_lane_t           prep [DIV_LANES];
  div_lane_t           nx  [DIV_ITER][DIV_LANES];
  word_t               fin [DIV_LANES];

  logic [WORD_WIDTH-1:0] mg [DIV_LANES];
  logic [WORD_WIDTH-1:0] hi [DIV_LANES];

  // Quotient saturates when its top part already reaches the denominator.
  always_comb begin
    for (int l = 0; l < DIV_LANES; l++) begin
      mg[l] = num[l][WORD_WIDTH-1] ? WORD_WIDTH'(-num[l]) : WORD_WIDTH'(num[l]);
      hi[l] = mg[l] >> HI_SH;
      prep[l].neg = num[l][WORD_WIDTH-1];
      prep[l].ovf = hi[l] >= WORD_WIDTH'(den[DIV_BITS-1:0]);
      prep[l].rem = DIV_BITS'(hi[l]);
      prep[l].nq  = DIV_BITS'({mg[l], {FRAC_BITS{1'b0}}});
    end
  end

  always_comb begin
    for (int g = 0; g < DIV_ITER; g++) begin
      for (int l = 0; l < DIV_LANES; l++) begin
        nx[g][l] = st[g][l];
        for (int j = 0; j < DIV_STEP; j++) begin
          if (g * DIV_STEP + j < DIV_BITS) begin
            nx[g][l] = div_step(nx[g][l], dv[g]);
          end
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < DIV_LANES; l++) begin
      if (st[DIV_ITER][l].ovf) begin
        fin[l] = st[DIV_ITER][l].neg ? WORD_MIN : WORD_MAX;
      end else if (st[DIV_ITER][l].neg) begin
        fin[l] = -$signed({1'b0, st[DIV_ITER][l].nq});
      end else begin
        fin[l] = $signed({1'b0, st[DIV_ITER][l].nq});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      st[0] <= prep;
      dv[0] <= den[DIV_BITS-1:0];
      bd[0] <= den[WORD_WIDTH-1] || (den == WORD_ZERO);
    end
    for (int g = 0; g < DIV_ITER; g++) begin
      if (ld[g+1]) begin
        st[g+1] <= nx[g];
        dv[g+1] <= dv[g];
        bd[g+1] <= bd[g];
      end
    end
    if (ld[DIV_LAT-1]) begin
      quo <= fin;
      bad <= bd[DIV_ITER];
    end
  end

endmodule

// ----- sv/projection_jacobian.sv -----
// Top level: pinhole projection Jacobian pipeline with SE3 pose.
//
// Takes requests into a 26-stage pipeline (quaternion products, rotation,
// transform, a 18-stage four-lane divider, Jacobian products and the output
// register), so a new request can enter before the last is through. Each request
// gives two result rows, the u row then the v row, on the single output channel,
// which holds each request until both rows are taken and so sets the sustained
// rate. Stalls and bubbles collapse stage by stage. Focal lengths come from the
// configuration port; the user must write them only while idle (not enforced).
module projection_jacobian (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  pj_pkg::in_t      in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output pj_pkg::out_t     out_data,
  input  logic             cfg_write,
  input  pj_pkg::cfg_idx_t cfg_index,
  input  pj_pkg::focal_t   cfg_data
);
  import pj_pkg::*;

  localparam int DIV_BASE = 4;
  localparam int E1   = DIV_BASE + DIV_LAT;
  localparam int E2   = E1 + 1;
  localparam int E3   = E2 + 1;
  localparam int OUT  = E3 + 1;
  localparam int NSTG = OUT + 1;

  focal_t focal_x;
  focal_t focal_y;
  word_t  fx;
  word_t  fy;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] ld;
  logic            row_sel;

  word_t s1_prod [9];
  word_t s1_t [3];
  word_t s1_p [3];
  word_t s2_rot [9];
  word_t s2_t [3];
  word_t s2_p [3];
  word_t s3_rp [9];
  word_t s3_t [3];
  word_t s3_rot [9];
  word_t s4_pc [3];
  word_t s4_rot [9];
  word_t rdl [DIV_LAT][9];

  word_t div_num [DIV_LANES];
  word_t quo [DIV_LANES];
  logic  dbad;

  word_t e1_ga, e1_fa, e1_fb, e1_gb, e1_yb, e1_ya, e1_gx, e1_gy, e1_a, e1_b;
  word_t e1_rot [9];
  logic  e1_bad;
  word_t e2_fab, e2_faa, e2_ybb, e2_yab, e2_u0, e2_u2, e2_u5, e2_v1, e2_v2, e2_v5;
  word_t e2_rot [9];
  logic  e2_bad;
  word_t e3_u0, e3_u2, e3_u3, e3_u4, e3_u5, e3_v1, e3_v2, e3_v3, e3_v4, e3_v5;
  word_t e3_pu0 [3];
  word_t e3_pu2 [3];
  word_t e3_pv1 [3];
  word_t e3_pv2 [3];
  logic  e3_bad;
  out_t  row_u, row_v, row_u_next, row_v_next;

  assign fx = WORD_WIDTH'(focal_x);
  assign fy = WORD_WIDTH'(focal_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x <= FOCAL_RESET;
      focal_y <= FOCAL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FOCAL_X: focal_x <= cfg_data;
        CFG_FOCAL_Y: focal_y <= cfg_data;
      endcase
    end
  end

  // A stage loads when it is empty or its contents move on.
  assign ld[OUT] = !vld[OUT] || (!out_stall && row_sel);
  for (genvar k = 0; k < OUT; k++) begin : g_ld
    assign ld[k] = !vld[k] || ld[k+1];
  end

  assign in_stall  = !ld[0];
  assign out_valid = vld[OUT];
  assign out_data  = row_sel ? row_v : row_u;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      row_sel <= 1'b0;
    end else begin
      if (ld[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (ld[k]) begin
          vld[k] <= vld[k-1];
        end
      end
      if (out_valid && !out_stall) begin
        row_sel <= !row_sel;
      end
    end
  end

  // Front: quaternion products, rotation matrix, R*P, camera point.
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_prod[0] <= qmul(in_data.quat_x, in_data.quat_x);
      s1_prod[1] <= qmul(in_data.quat_y, in_data.quat_y);
      s1_prod[2] <= qmul(in_data.quat_z, in_data.quat_z);
      s1_prod[3] <= qmul(in_data.quat_x, in_data.quat_y);
      s1_prod[4] <= qmul(in_data.quat_x, in_data.quat_z);
      s1_prod[5] <= qmul(in_data.quat_y, in_data.quat_z);
      s1_prod[6] <= qmul(in_data.quat_w, in_data.quat_x);
      s1_prod[7] <= qmul(in_data.quat_w, in_data.quat_y);
      s1_prod[8] <= qmul(in_data.quat_w, in_data.quat_z);
      s1_t[0] <= in_data.trans_x;
      s1_t[1] <= in_data.trans_y;
      s1_t[2] <= in_data.trans_z;
      s1_p[0] <= in_data.point_x;
      s1_p[1] <= in_data.point_y;
      s1_p[2] <= in_data.point_z;
    end
    // products: xx yy zz xy xz yz wx wy wz
    if (ld[1]) begin
      s2_rot[0] <= qsub(WORD_ONE, dbl(qadd(s1_prod[1], s1_prod[2])));
      s2_rot[1] <= dbl(qsub(s1_prod[3], s1_prod[8]));
      s2_rot[2] <= dbl(qadd(s1_prod[4], s1_prod[7]));
      s2_rot[3] <= dbl(qadd(s1_prod[3], s1_prod[8]));
      s2_rot[4] <= qsub(WORD_ONE, dbl(qadd(s1_prod[0], s1_prod[2])));
      s2_rot[5] <= dbl(qsub(s1_prod[5], s1_prod[6]));
      s2_rot[6] <= dbl(qsub(s1_prod[4], s1_prod[7]));
      s2_rot[7] <= dbl(qadd(s1_prod[5], s1_prod[6]));
      s2_rot[8] <= qsub(WORD_ONE, dbl(qadd(s1_prod[0], s1_prod[1])));
      s2_t <= s1_t;
      s2_p <= s1_p;
    end
    if (ld[2]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s3_rp[i*3+j] <= qmul(s2_rot[i*3+j], s2_p[j]);
        end
      end
      s3_t   <= s2_t;
      s3_rot <= s2_rot;
    end
    if (ld[3]) begin
      for (int i = 0; i < 3; i++) begin
        s4_pc[i] <= qadd(qadd(qadd(s3_rp[i*3], s3_rp[i*3+1]), s3_rp[i*3+2]), s3_t[i]);
      end
      s4_rot <= s3_rot;
    end
    // Carry the rotation alongside the divider.
    if (ld[DIV_BASE]) begin
      rdl[0] <= s4_rot;
    end
    for (int k = 1; k < DIV_LAT; k++) begin
      if (ld[DIV_BASE+k]) begin
        rdl[k] <= rdl[k-1];
      end
    end
  end

  // Lanes: X/Z, Y/Z, fx/Z, fy/Z.
  assign div_num[0] = s4_pc[0];
  assign div_num[1] = s4_pc[1];
  assign div_num[2] = fx;
  assign div_num[3] = fy;

  pj_div u_div (
    .clk (clk),
    .ld  (ld[DIV_BASE +: DIV_LAT]),
    .num (div_num),
    .den (s4_pc[2]),
    .quo (quo),
    .bad (dbad)
  );

  // Back: Jacobian entries and landmark rows.
  always_ff @(posedge clk) begin
    if (ld[E1]) begin
      e1_ga  <= qmul(quo[2], quo[0]);
      e1_fa  <= qmul(fx, quo[0]);
      e1_fb  <= qmul(fx, quo[1]);
      e1_gb  <= qmul(quo[3], quo[1]);
      e1_yb  <= qmul(fy, quo[1]);
      e1_ya  <= qmul(fy, quo[0]);
      e1_gx  <= quo[2];
      e1_gy  <= quo[3];
      e1_a   <= quo[0];
      e1_b   <= quo[1];
      e1_rot <= rdl[DIV_LAT-1];
      e1_bad <= dbad;
    end
    if (ld[E2]) begin
      e2_fab <= qmul(e1_fa, e1_b);
      e2_faa <= qmul(e1_fa, e1_a);
      e2_ybb <= qmul(e1_yb, e1_b);
      e2_yab <= qmul(e1_ya, e1_b);
      e2_u0  <= e1_gx;
      e2_u2  <= qsub(WORD_ZERO, e1_ga);
      e2_u5  <= qsub(WORD_ZERO, e1_fb);
      e2_v1  <= e1_gy;
      e2_v2  <= qsub(WORD_ZERO, e1_gb);
      e2_v5  <= e1_ya;
      e2_rot <= e1_rot;
      e2_bad <= e1_bad;
    end
    if (ld[E3]) begin
      e3_u0 <= e2_u0;
      e3_u2 <= e2_u2;
      e3_u3 <= qsub(WORD_ZERO, e2_fab);
      e3_u4 <= qadd(fx, e2_faa);
      e3_u5 <= e2_u5;
      e3_v1 <= e2_v1;
      e3_v2 <= e2_v2;
      e3_v3 <= qsub(qsub(WORD_ZERO, fy), e2_ybb);
      e3_v4 <= e2_yab;
      e3_v5 <= e2_v5;
      for (int j = 0; j < 3; j++) begin
        e3_pu0[j] <= qmul(e2_u0, e2_rot[j]);
        e3_pu2[j] <= qmul(e2_u2, e2_rot[6+j]);
        e3_pv1[j] <= qmul(e2_v1, e2_rot[3+j]);
        e3_pv2[j] <= qmul(e2_v2, e2_rot[6+j]);
      end
      e3_bad <= e2_bad;
    end
    if (ld[OUT]) begin
      row_u <= row_u_next;
      row_v <= row_v_next;
    end
  end

  always_comb begin
    row_u_next = '0;
    row_v_next = '0;
    row_u_next.last_row  = 1'b0;
    row_v_next.last_row  = 1'b1;
    row_u_next.bad_depth = e3_bad;
    row_v_next.bad_depth = e3_bad;
    // Leave every entry zero when the point sits at or behind the camera.
    if (!e3_bad) begin
      row_u_next.pose_d0  = e3_u0;
      row_u_next.pose_d2  = e3_u2;
      row_u_next.pose_d3  = e3_u3;
      row_u_next.pose_d4  = e3_u4;
      row_u_next.pose_d5  = e3_u5;
      row_u_next.point_d0 = qadd(e3_pu0[0], e3_pu2[0]);
      row_u_next.point_d1 = qadd(e3_pu0[1], e3_pu2[1]);
      row_u_next.point_d2 = qadd(e3_pu0[2], e3_pu2[2]);
      row_v_next.pose_d1  = e3_v1;
      row_v_next.pose_d2  = e3_v2;
      row_v_next.pose_d3  = e3_v3;
      row_v_next.pose_d4  = e3_v4;
      row_v_next.pose_d5  = e3_v5;
      row_v_next.point_d0 = qadd(e3_pv1[0], e3_pv2[0]);
      row_v_next.point_d1 = qadd(e3_pv1[1], e3_pv2[1]);
      row_v_next.point_d2 = qadd(e3_pv1[2], e3_pv2[2]);
    end
  end

  a_row_idle: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !row_sel)
    else $error("row select set with no result held");

  a_v_follows_u: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !row_sel |=> out_valid && row_sel)
    else $error("v row missing after u row");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bad_depth |->
      out_data.pose_d0 == WORD_ZERO && out_data.pose_d4 == WORD_ZERO &&
      out_data.point_d2 == WORD_ZERO)
    else $error("entries not cleared on bad depth");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> vld[0] && vld[OUT])
    else $error("input stalled with room in pipeline");

endmodule
